FILE: hw/rtl/plid_pkg.sv
package plid_pkg;

    localparam int DEPTH       = 16;
    localparam int VALUE_WIDTH = 32;

    localparam int POS_W  = 5;
    localparam int DATA_W = 32;
    localparam int LEN_W  = 5;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_GET    = 2'd2,
        CMD_CLEAR  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_BUSY = 1'b1
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic exec;
    } ctl_t;

    // datapath -> observers
    typedef struct packed {
        logic full;
        logic empty;
    } dp_stat_t;

endpackage

FILE: hw/rtl/plid_req_if.sv
interface plid_req_if;
    import plid_pkg::*;

    logic                valid;
    logic                ready;
    cmd_t                cmd;
    logic [POS_W-1:0]    position;
    logic [DATA_W-1:0]   item_value;

    modport source (output valid, output cmd, output position, output item_value,
                    input ready);
    modport sink   (input valid, input cmd, input position, input item_value,
                    output ready);
endinterface

FILE: hw/rtl/plid_rsp_if.sv
interface plid_rsp_if;
    import plid_pkg::*;

    logic                valid;
    logic                ready;
    status_t             status;
    logic [DATA_W-1:0]   read_value;
    logic [LEN_W-1:0]    list_length;

    modport source (output valid, output status, output read_value, output list_length,
                    input ready);
    modport sink   (input valid, input status, input read_value, input list_length,
                    output ready);
endinterface

FILE: hw/rtl/plid_ctrl.sv
module plid_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output plid_pkg::ctl_t ctl
);
    import plid_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        rsp_valid  = 1'b0;
        req_ready  = 1'b0;
        ctl.exec   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                ctl.exec  = req_valid;
                if (req_valid)
                begin
                    state_next = S_BUSY;
                end
            end
            S_BUSY:
            begin
                rsp_valid = 1'b1;
                // a taken result frees the output register for the next command
                req_ready = rsp_ready;
                ctl.exec  = req_valid && rsp_ready;
                if (rsp_ready && !req_valid)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: hw/rtl/plid_dp.sv
module plid_dp (
    input  logic                      clk,
    input  logic                      rst_n,
    input  plid_pkg::ctl_t            ctl,
    input  plid_pkg::cmd_t            cmd,
    input  logic [plid_pkg::POS_W-1:0]  position,
    input  logic [plid_pkg::DATA_W-1:0] item_value,
    output plid_pkg::status_t         status,
    output logic [plid_pkg::DATA_W-1:0] read_value,
    output logic [plid_pkg::LEN_W-1:0]  list_length,
    output plid_pkg::dp_stat_t        stat
);
    import plid_pkg::*;

    // row of entry cells; only cells below the count hold meaning
    logic [VALUE_WIDTH-1:0] cell_reg  [DEPTH];
    logic [VALUE_WIDTH-1:0] cell_next [DEPTH];
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    status_t                status_reg;
    status_t                status_next;
    logic [DATA_W-1:0]      read_reg;
    logic [DATA_W-1:0]      read_next;

    logic [CMP_W-1:0]       pos_ext;
    logic [CMP_W-1:0]       cnt_ext;
    logic [CMP_W-1:0]       ins_pos;
    logic                   in_range;
    logic                   is_full;
    logic [VALUE_WIDTH-1:0] sel_entry;

    assign pos_ext   = CMP_W'(position);
    assign cnt_ext   = CMP_W'(count_reg);
    assign in_range  = pos_ext < cnt_ext;
    assign is_full   = count_reg == CNT_W'(DEPTH);
    // clamp insert position to append
    assign ins_pos   = (pos_ext > cnt_ext) ? cnt_ext : pos_ext;
    assign sel_entry = cell_reg[position[IDX_W-1:0]];

    always_comb
    begin
        cell_next   = cell_reg;
        count_next  = count_reg;
        status_next = status_reg;
        read_next   = read_reg;
        if (ctl.exec)
        begin
            status_next = ST_OK;
            read_next   = '0;
            unique case (cmd)
                CMD_INSERT:
                begin
                    if (is_full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        for (int i = 0; i < DEPTH; i++)
                        begin
                            if (CMP_W'(i) == ins_pos)
                            begin
                                cell_next[i] = item_value[VALUE_WIDTH-1:0];
                            end
                            else if ((i > 0) && (CMP_W'(i) > ins_pos))
                            begin
                                cell_next[i] = cell_reg[(i > 0) ? i - 1 : 0];
                            end
                        end
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                CMD_DELETE:
                begin
                    if (!in_range)
                    begin
                        status_next = ST_RANGE;
                    end
                    else
                    begin
                        read_next = DATA_W'(sel_entry);
                        for (int i = 0; i < DEPTH - 1; i++)
                        begin
                            if (CMP_W'(i) >= pos_ext)
                            begin
                                cell_next[i] = cell_reg[i + 1];
                            end
                        end
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                CMD_GET:
                begin
                    if (!in_range)
                    begin
                        status_next = ST_RANGE;
                    end
                    else
                    begin
                        read_next = DATA_W'(sel_entry);
                    end
                end
                CMD_CLEAR:
                begin
                    count_next = '0;
                end
                default:
                begin
                    count_next = count_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        cell_reg   <= cell_next;
        read_reg   <= read_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            status_reg <= ST_OK;
        end
        else
        begin
            count_reg  <= count_next;
            status_reg <= status_next;
        end
    end

    assign status      = status_reg;
    assign read_value  = read_reg;
    assign list_length = LEN_W'(count_reg);
    assign stat.full   = is_full;
    assign stat.empty  = count_reg == '0;

endmodule

FILE: hw/rtl/positional_list_insert_delete.sv
// Channel | Dir | Payload                             | Transfer
// --------+-----+-------------------------------------+---------------------
// req     | in  | cmd, position, item_value           | valid && ready
// rsp     | out | status, read_value, list_length     | valid && ready
//
// Each command is executed in the cycle of its transfer: the row of entry
// cells shifts up or down in one step and the result lands in the output
// register, so one command can enter every cycle while rsp is taken.
// A pending result holds the output register; req.ready follows rsp.ready
// while it waits, so a stall on rsp stalls req in the same cycle.
// Reset (rst_n, asynchronous, active low) empties the list and drops any
// pending result; the entry cells themselves are not cleared.
module positional_list_insert_delete (
    input  logic clk,
    input  logic rst_n,
    plid_req_if.sink   req,
    plid_rsp_if.source rsp
);
    import plid_pkg::*;

    ctl_t     ctl;
    dp_stat_t stat;

    // handshake sequencing: decides when a command executes
    plid_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .ctl       (ctl)
    );

    // entry cells, count and result register
    plid_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .cmd         (req.cmd),
        .position    (req.position),
        .item_value  (req.item_value),
        .status      (rsp.status),
        .read_value  (rsp.read_value),
        .list_length (rsp.list_length),
        .stat        (stat)
    );

    // A command only executes when the output register is free or being drained.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.exec |-> !(rsp.valid && !rsp.ready))
        else $error("command executed over a pending result");

    // Length never passes capacity and full agrees with it.
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.list_length <= LEN_W'(DEPTH)) && (stat.full == (rsp.list_length == LEN_W'(DEPTH))))
        else $error("list length out of bounds");

    // An accepted clear yields an empty list with ok status.
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready && req.cmd == CMD_CLEAR) |=>
            (rsp.valid && rsp.list_length == '0 && rsp.status == ST_OK && stat.empty))
        else $error("clear did not empty the list");

    // Insert into a full list is refused and leaves the length at capacity.
    a_full_insert: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready && req.cmd == CMD_INSERT && stat.full) |=>
            (rsp.status == ST_FULL && stat.full && rsp.read_value == '0))
        else $error("insert into full list not refused");

endmodule

FILE: sim/positional_list_insert_delete_test.sv
module positional_list_insert_delete_test;
    import plid_pkg::*;

    // Commands queued for the request driver, and results still owed by the block.
    typedef struct {
        cmd_t              cmd;
        logic [POS_W-1:0]  position;
        logic [DATA_W-1:0] item_value;
        bit                drain_first;  // hold off until every owed result is back
    } list_cmd_t;

    typedef struct {
        status_t           status;
        logic [DATA_W-1:0] read_value;
        logic [LEN_W-1:0]  list_length;
    } list_rsp_t;

    localparam int RANDOM_ITEMS = 1900;
    localparam int CALM_TAIL    = 150;     // final stretch with no idling on either side
    localparam int HOLDOFF_AT   = 600;     // results seen before the long receiver stall
    localparam int HOLDOFF_LEN  = 400;
    localparam int SETTLE       = 20;
    localparam int CYCLE_LIMIT  = 250000;

    logic clk;
    logic rst_n;

    plid_req_if req_if ();
    plid_rsp_if rsp_if ();

    positional_list_insert_delete dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    list_cmd_t cmd_backlog[$];
    list_rsp_t pending_responses[$];

    // Shadow of the list contents, updated once per accepted command.
    logic [VALUE_WIDTH-1:0] shadow_cells [DEPTH];
    int                     shadow_count = 0;

    int stim_total     = 0;
    int gen_len        = 0;   // length tracked while building stimulus, steers positions
    int popped_count   = 0;
    int accepted_count = 0;
    int seen_count     = 0;
    int fail_count     = 0;
    int cycle_count    = 0;
    int gap_left       = 0;
    int stall_left     = 0;
    int holdoff_left   = 0;
    bit holdoff_done   = 1'b0;
    bit calm_phase     = 1'b0;
    list_cmd_t cur_cmd;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Apply one command to the shadow list and return the result it must produce.
    function automatic list_rsp_t compute_list_response(list_cmd_t c);
        list_rsp_t r;
        int        p;
        int        i;
        r.status     = ST_OK;
        r.read_value = '0;
        p = c.position;
        case (c.cmd)
            CMD_INSERT:
            begin
                if (shadow_count >= DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    // a position past the end appends
                    if (p > shadow_count)
                        p = shadow_count;
                    for (i = shadow_count; i > p; i--)
                        shadow_cells[i] = shadow_cells[i-1];
                    shadow_cells[p] = c.item_value[VALUE_WIDTH-1:0];
                    shadow_count++;
                end
            end
            CMD_DELETE:
            begin
                if (p >= shadow_count)
                    r.status = ST_RANGE;
                else
                begin
                    r.read_value = DATA_W'(shadow_cells[p]);
                    for (i = p; i + 1 < shadow_count; i++)
                        shadow_cells[i] = shadow_cells[i+1];
                    shadow_count--;
                end
            end
            CMD_GET:
            begin
                if (p >= shadow_count)
                    r.status = ST_RANGE;
                else
                    r.read_value = DATA_W'(shadow_cells[p]);
            end
            default:
                shadow_count = 0;
        endcase
        r.list_length = LEN_W'(shadow_count);
        return r;
    endfunction

    // Queue one command; track the list length so later positions land in range.
    task automatic add_cmd(cmd_t c, int unsigned pos, logic [DATA_W-1:0] v, bit drain);
        list_cmd_t item;
        item.cmd         = c;
        item.position    = POS_W'(pos);
        item.item_value  = v;
        item.drain_first = drain;
        cmd_backlog.push_back(item);
        stim_total++;
        case (c)
            CMD_INSERT: if (gen_len < DEPTH) gen_len++;
            CMD_DELETE: if (item.position < gen_len) gen_len--;
            CMD_CLEAR:  gen_len = 0;
            default:    ;
        endcase
    endtask

    // Pick a position: mostly inside the current list, sometimes anywhere in the field.
    function automatic int unsigned pick_position(cmd_t c);
        if ($urandom_range(0, 4) == 0)
            return $urandom_range(0, 31);
        if (c == CMD_INSERT)
            return $urandom_range(0, gen_len);
        if (gen_len == 0)
            return 0;
        return $urandom_range(0, gen_len - 1);
    endfunction

    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // Stimulus, reset and end of run.
    initial
    begin
        int   i;
        int   n;
        int   mode;
        int   roll;
        cmd_t c;

        rst_n             = 1'b0;
        req_if.valid      = 1'b0;
        req_if.cmd        = CMD_INSERT;
        req_if.position   = '0;
        req_if.item_value = '0;
        rsp_if.ready      = 1'b0;

        // Directed: empty-list range errors, append past the end, front insert,
        // reads at and past the length, fill to full, insert into full, clear.
        add_cmd(CMD_GET,    0,  '0, 1'b0);
        add_cmd(CMD_DELETE, 0,  '0, 1'b0);
        add_cmd(CMD_INSERT, 31, 32'hFFFF_FFFF, 1'b0);
        add_cmd(CMD_INSERT, 0,  32'h0000_0000, 1'b0);
        add_cmd(CMD_GET,    0,  32'hFFFF_FFFF, 1'b0);
        add_cmd(CMD_GET,    1,  '0, 1'b0);
        add_cmd(CMD_GET,    2,  '0, 1'b0);
        add_cmd(CMD_DELETE, 31, '0, 1'b0);
        for (i = 0; i < DEPTH - 2; i++)
            add_cmd(CMD_INSERT, $urandom_range(0, 16), $urandom, 1'b0);
        add_cmd(CMD_INSERT, 5,  32'hA5A5_5A5A, 1'b0);
        add_cmd(CMD_GET,    15, '0, 1'b0);
        add_cmd(CMD_DELETE, 15, '0, 1'b0);
        add_cmd(CMD_DELETE, 0,  '0, 1'b0);
        add_cmd(CMD_CLEAR,  16, 32'hFFFF_FFFF, 1'b0);

        // Random: blocks biased toward filling, draining or a mix, so the list
        // spends time at every length including full and empty.
        n = 0;
        while (n < RANDOM_ITEMS)
        begin
            mode = $urandom_range(0, 2);
            for (i = 0; i < 50 && n < RANDOM_ITEMS; i++)
            begin
                roll = $urandom_range(0, 99);
                case (mode)
                    0:       c = (roll < 65) ? CMD_INSERT : (roll < 80) ? CMD_DELETE :
                                 (roll < 98) ? CMD_GET : CMD_CLEAR;
                    1:       c = (roll < 20) ? CMD_INSERT : (roll < 75) ? CMD_DELETE :
                                 (roll < 98) ? CMD_GET : CMD_CLEAR;
                    default: c = (roll < 35) ? CMD_INSERT : (roll < 65) ? CMD_DELETE :
                                 (roll < 95) ? CMD_GET : CMD_CLEAR;
                endcase
                // drain the block completely at two points of the run
                add_cmd(c, pick_position(c), pick_value(), (n == 0) || (n == 1100));
                n++;
            end
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (accepted_count < stim_total)
            @(posedge clk);
        while (pending_responses.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Request driver: record the transfer, then offer the next command or idle.
    always @(posedge clk)
    begin
        bit        next_valid;
        list_cmd_t next_cmd;
        next_valid = req_if.valid;
        if (rst_n)
        begin
            if (req_if.valid && req_if.ready)
            begin
                pending_responses.push_back(compute_list_response(cur_cmd));
                accepted_count++;
                next_valid = 1'b0;
            end
            if (!next_valid)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (cmd_backlog.size() != 0 &&
                         !(cmd_backlog[0].drain_first && pending_responses.size() != 0))
                begin
                    next_cmd = cmd_backlog.pop_front();
                    cur_cmd  = next_cmd;
                    popped_count++;
                    calm_phase = (popped_count >= stim_total - CALM_TAIL);
                    req_if.cmd        <= next_cmd.cmd;
                    req_if.position   <= next_cmd.position;
                    req_if.item_value <= next_cmd.item_value;
                    next_valid = 1'b1;
                    // leave a gap after this transfer now and then, except in quiet stretches
                    if (!calm_phase && ((popped_count / 150) % 4 != 2) &&
                        $urandom_range(0, 6) == 0)
                        gap_left = $urandom_range(1, 14);
                end
            end
        end
        req_if.valid <= next_valid;
    end

    // Response monitor: check each transfer against the oldest owed result,
    // then decide whether to stall.
    always @(posedge clk)
    begin
        bit        next_ready;
        list_rsp_t want;
        next_ready = rsp_if.ready;
        if (rst_n)
        begin
            if (rsp_if.valid && rsp_if.ready)
            begin
                seen_count++;
                if (pending_responses.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected response: status %0d read_value %h length %0d",
                                 rsp_if.status, rsp_if.read_value, rsp_if.list_length);
                end
                else
                begin
                    want = pending_responses.pop_front();
                    if (rsp_if.status !== want.status ||
                        rsp_if.read_value !== want.read_value ||
                        rsp_if.list_length !== want.list_length)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"mismatch on response %0d: ",
                                      "expected status %0d value %h length %0d, ",
                                      "got status %0d value %h length %0d"},
                                     seen_count, want.status, want.read_value,
                                     want.list_length, rsp_if.status,
                                     rsp_if.read_value, rsp_if.list_length);
                    end
                end
            end

            // one long stall while the driver keeps offering: back up the block
            if (!holdoff_done && seen_count >= HOLDOFF_AT)
            begin
                holdoff_done = 1'b1;
                holdoff_left = HOLDOFF_LEN;
            end

            if (holdoff_left > 0)
            begin
                holdoff_left--;
                next_ready = 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                next_ready = 1'b0;
            end
            else
            begin
                next_ready = 1'b1;
                if (!calm_phase && ((seen_count / 150) % 4 != 1) &&
                    $urandom_range(0, 6) == 0)
                    stall_left = $urandom_range(1, 14);
            end
        end
        rsp_if.ready <= next_ready;
    end

    // Watchdog: stop a hung run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

endmodule
